// ----- hw/rtl/bba_pkg.sv -----
`timescale 1ns / 1ps

package bba_pkg;

  // Field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned INDEX_W = 12;
  localparam int unsigned CFG_W   = 13;

  // Storage organization
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned BIT_W       = 6;
  localparam int unsigned INDEX_LIMIT = 4096;
  localparam int unsigned NUM_BLOCKS_DEF = 4096;

  // Block count after reset
  localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

  // Request operation codes
  typedef enum logic [OP_W-1:0] {
    OP_FREE   = 2'd0,
    OP_OCCUPY = 2'd1,
    OP_ALLOC  = 2'd2
  } op_e;

endpackage

// ----- hw/rtl/block_bitmap_allocator_top.sv -----
`timescale 1ns / 1ps

// Sequence: free/occupy requests pass through ST_MARK and ST_RESP, refused requests go straight to ST_RESP;
// allocate scans the 64-bit bitmap words in ST_SCAN (up to 64 words at 4096 blocks), then goes to ST_RESP.
// Throughput: one request at a time; the single-port bitmap RAM read-modify-write and the
// word-by-word first-fit scan set the figure. A finished result waits in the output register.
// Reset: asynchronous, active low; a clearing pass then writes every bitmap word to free, one word
// per cycle, while requests are stalled.
module block_bitmap_allocator_top #(
  parameter int unsigned NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bba_pkg::CFG_W-1:0]   cfg_data_i,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [bba_pkg::OP_W-1:0]    operation_i,
  input  logic [bba_pkg::INDEX_W-1:0] blk_id_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bba_pkg::INDEX_W-1:0] block_index_o,
  output logic                        success_o
);
  import bba_pkg::*;

  localparam int unsigned USED_BLOCKS = (NUM_BLOCKS < INDEX_LIMIT) ? NUM_BLOCKS : INDEX_LIMIT;
  localparam int unsigned WORDS       = (USED_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int unsigned AW          = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [CFG_W-1:0] USED_CNT = CFG_W'(USED_BLOCKS);
  localparam logic [AW-1:0]    LAST_WORD = AW'(WORDS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MARK,
    ST_SCAN,
    ST_RESP
  } state_e;

  state_e               state_q;
  logic [CFG_W-1:0]     cfg_q;
  logic [CFG_W-1:0]     count_q;
  logic [OP_W-1:0]      op_q;
  logic [INDEX_W-1:0]   blk_q;
  logic [AW-1:0]        widx_q;
  logic [INDEX_W-1:0]   res_idx_q;
  logic                 res_ok_q;
  logic                 out_valid_q;
  logic [INDEX_W-1:0]   out_idx_q;
  logic                 out_ok_q;

  // bitmap memory
  logic [WORD_W-1:0]    mem [WORDS];
  logic [WORD_W-1:0]    rdata_q;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_W-1:0]    wr_data;

  logic                 in_fire;
  logic [CFG_W-1:0]     eff_count;
  logic                 in_range;
  logic [CFG_W-1:0]     rem;
  logic                 last_word;
  logic [WORD_W-1:0]    avail;
  logic                 found;
  logic [BIT_W-1:0]     pos;
  logic                 out_free;
  logic                 res_load;

  assign cfg_ready_o   = 1'b1;
  assign in_stall_o    = (state_q != ST_IDLE);
  assign in_fire       = in_valid_i && (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign block_index_o = out_idx_q;
  assign success_o     = out_ok_q;
  assign out_free      = !out_valid_q || !out_stall_i;
  assign res_load      = (state_q == ST_RESP) && out_free;

  // Saturate the block count to the bitmap size
  assign eff_count = (cfg_q > USED_CNT) ? USED_CNT : cfg_q;
  assign in_range  = ({1'b0, blk_id_i} < eff_count);

  // Mask lanes at or past the block count and find the first free bit
  assign rem       = count_q - CFG_W'({widx_q, {BIT_W{1'b0}}});
  assign last_word = (widx_q == LAST_WORD) || (rem <= CFG_W'(WORD_W));

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      avail[b] = !rdata_q[b] && (CFG_W'(b) < rem);
    end
  end

  always_comb begin
    pos = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (avail[b]) pos = BIT_W'(b);
    end
  end

  assign found = |avail;

  // Memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = widx_q;
    wr_data = rdata_q;
    case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = '0;
      end
      ST_IDLE: begin
        rd_en   = in_fire;
        rd_addr = (operation_i == OP_ALLOC) ? '0 : AW'(blk_id_i >> BIT_W);
      end
      ST_MARK: begin
        wr_en   = 1'b1;
        wr_addr = AW'(blk_q >> BIT_W);
        wr_data[blk_q[BIT_W-1:0]] = (op_q == OP_OCCUPY);
      end
      ST_SCAN: begin
        rd_en   = !found && !last_word;
        rd_addr = widx_q + AW'(1);
        wr_en   = found;
        wr_data[pos] = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      widx_q      <= '0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      op_q        <= '0;
      blk_q       <= '0;
      res_idx_q   <= '0;
      res_ok_q    <= 1'b0;
      out_idx_q   <= '0;
      out_ok_q    <= 1'b0;
    end else begin
      // load a new result, or drop the old one once taken
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_CLEAR: begin
          if (widx_q == LAST_WORD) begin
            widx_q  <= '0;
            state_q <= ST_IDLE;
          end else begin
            widx_q <= widx_q + AW'(1);
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            op_q      <= operation_i;
            blk_q     <= blk_id_i;
            count_q   <= eff_count;
            widx_q    <= '0;
            res_idx_q <= '0;
            res_ok_q  <= 1'b0;
            case (operation_i)
              OP_FREE, OP_OCCUPY: state_q <= in_range ? ST_MARK : ST_RESP;
              OP_ALLOC:           state_q <= ST_SCAN;
              default:            state_q <= ST_RESP;
            endcase
          end
        end
        ST_MARK: begin
          res_idx_q <= blk_q;
          res_ok_q  <= 1'b1;
          state_q   <= ST_RESP;
        end
        ST_SCAN: begin
          if (found) begin
            res_idx_q <= INDEX_W'({widx_q, pos});
            res_ok_q  <= 1'b1;
            state_q   <= ST_RESP;
          end else if (last_word) begin
            state_q <= ST_RESP;
          end else begin
            widx_q <= widx_q + AW'(1);
          end
        end
        ST_RESP: begin
          if (out_free) begin
            out_idx_q   <= res_idx_q;
            out_ok_q    <= res_ok_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
